// ===== hw/rtl/tcps_pkg.sv =====
`default_nettype none

package tcps_pkg;

  // Default width of absolute time values (seconds)
  localparam int TIME_WIDTH_DEF = 32;

  // Duration registers, cycle length and divider remainder widths
  localparam int DUR_W = 14;
  localparam int LEN_W = DUR_W + 1;
  localparam int REM_W = LEN_W + 1;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIME   = 3'd0,
    REG_TX_TIME      = 3'd1,
    REG_PAUSE_TIME   = 3'd2,
    REG_TONE_LENGTH  = 3'd3,
    REG_PREP_TIME    = 3'd4,
    REG_CONT_MODE    = 3'd5
  } cfg_reg_t;

  // Action codes of an input beat
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  typedef enum logic [1:0] {
    PH_TX    = 2'd0,
    PH_TONE  = 2'd1,
    PH_PAUSE = 2'd2,
    PH_READY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_FIN  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcps_ifs.sv =====
`default_nettype none

interface tcps_in_if #(parameter int TIME_WIDTH = tcps_pkg::TIME_WIDTH_DEF);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [TIME_WIDTH-1:0] current_time;
  logic                  before_finish;
  logic                  fox_prepared;

  modport source (output valid, action, current_time, before_finish, fox_prepared,
                  input ready);
  modport sink   (input valid, action, current_time, before_finish, fox_prepared,
                  output ready);
endinterface

interface tcps_out_if #(parameter int TIME_WIDTH = tcps_pkg::TIME_WIDTH_DEF);
  logic                  valid;
  logic                  ready;
  logic [1:0]            phase;
  logic                  ending_tone_on;
  logic [TIME_WIDTH-1:0] next_change_time;
  logic                  do_prepare;
  logic                  do_unprepare;
  logic                  morse_start;
  logic                  morse_stop;
  logic                  keyer_notify;
  logic                  fault;

  modport source (output valid, phase, ending_tone_on, next_change_time, do_prepare,
                         do_unprepare, morse_start, morse_stop, keyer_notify, fault,
                  input ready);
  modport sink   (input valid, phase, ending_tone_on, next_change_time, do_prepare,
                        do_unprepare, morse_start, morse_stop, keyer_notify, fault,
                  output ready);
endinterface

interface tcps_cfg_if #(parameter int TIME_WIDTH = tcps_pkg::TIME_WIDTH_DEF);
  logic                             valid;
  logic                             ready;
  logic [tcps_pkg::CFG_IDX_W-1:0]   index;
  logic [TIME_WIDTH-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/transmit_cycle_phase_sequencer.sv =====
// Transmit cycle phase sequencer.
// Channels: cfg_if writes one register per beat (index 0 start time, 1 tx time,
// 2 pause time, 3 ending tone length, 4 preparation time, 5 continuous mode);
// always ready. Write only while the block is idle.
// in_if takes one beat: a tick, a start or a stop command with the current time.
// out_if returns exactly one result beat per input beat: the stored phase, tone
// flag, next change time, one-beat command pulses and the sticky fault.
// Path: a tick that needs the cycle position passes the serial divider (one
// remainder bit per cycle) and then the state update; every other beat goes
// straight to the state update.
// Flow: one beat is in work at a time and the sequencer returns to idle to take
// the next; the previous result may still sit in the output register.
// Stall: if out_if is not ready, the finished result waits in the sequencer until
// the output register frees; no beat is dropped.
// Reset (rst_n low, synchronous): phase pause, tone off, change time 0, fault
// cleared, registers back to defaults (60 s tx, 240 s pause, 5 s tone and prep).
`default_nettype none

module transmit_cycle_phase_sequencer #(
  parameter int TIME_WIDTH = tcps_pkg::TIME_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tcps_cfg_if.sink    cfg_if,
  tcps_in_if.sink     in_if,
  tcps_out_if.source  out_if
);

  tcps_pkg::dp_cmd_t  cmd;
  tcps_pkg::dp_stat_t stat;

  // Configuration writes are always accepted and registered directly
  assign cfg_if.ready = 1'b1;

  tcps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcps_dp #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .cfg_we               (cfg_if.valid),
    .cfg_index            (cfg_if.index),
    .cfg_data             (cfg_if.data),
    .in_action            (in_if.action),
    .in_current_time      (in_if.current_time),
    .in_before_finish     (in_if.before_finish),
    .in_fox_prepared      (in_if.fox_prepared),
    .out_ready            (out_if.ready),
    .out_valid            (out_if.valid),
    .out_phase            (out_if.phase),
    .out_ending_tone_on   (out_if.ending_tone_on),
    .out_next_change_time (out_if.next_change_time),
    .out_do_prepare       (out_if.do_prepare),
    .out_do_unprepare     (out_if.do_unprepare),
    .out_morse_start      (out_if.morse_start),
    .out_morse_stop       (out_if.morse_stop),
    .out_keyer_notify     (out_if.keyer_notify),
    .out_fault            (out_if.fault)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/tcps_ctrl.sv =====
`default_nettype none

module tcps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tcps_pkg::dp_stat_t stat,
  output tcps_pkg::dp_cmd_t       cmd
);

  tcps_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tcps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.need_div ? tcps_pkg::ST_DIV : tcps_pkg::ST_FIN;
        end
      end
      tcps_pkg::ST_DIV: begin
        // one quotient bit per cycle
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_nxt = tcps_pkg::ST_FIN;
        end
      end
      tcps_pkg::ST_FIN: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = tcps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcps_dp.sv =====
`default_nettype none

module tcps_dp #(
  parameter int TIME_WIDTH = tcps_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tcps_pkg::dp_cmd_t              cmd,
  output tcps_pkg::dp_stat_t                  stat,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [tcps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_WIDTH-1:0]          cfg_data,
  // input beat fields
  input  wire logic [1:0]                     in_action,
  input  wire logic [TIME_WIDTH-1:0]          in_current_time,
  input  wire logic                           in_before_finish,
  input  wire logic                           in_fox_prepared,
  // result register
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [1:0]                          out_phase,
  output logic                                out_ending_tone_on,
  output logic [TIME_WIDTH-1:0]               out_next_change_time,
  output logic                                out_do_prepare,
  output logic                                out_do_unprepare,
  output logic                                out_morse_start,
  output logic                                out_morse_stop,
  output logic                                out_keyer_notify,
  output logic                                out_fault
);

  localparam int DUR_W = tcps_pkg::DUR_W;
  localparam int LEN_W = tcps_pkg::LEN_W;
  localparam int REM_W = tcps_pkg::REM_W;
  localparam int CNT_W = $clog2(TIME_WIDTH);

  // configuration
  logic [TIME_WIDTH-1:0] start_r;
  logic [DUR_W-1:0]      tx_r, pause_r, tone_len_r, prep_time_r;
  logic                  cont_r;

  // sequencer state
  tcps_pkg::phase_t      phase_r, phase_nxt;
  logic                  tone_r, tone_nxt;
  logic                  halted_r, halted_nxt;
  logic [TIME_WIDTH-1:0] change_r;

  // latched beat
  logic [1:0]            act_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic                  bf_r;
  logic                  fox_r;
  logic                  early_r;

  // serial divider
  logic [TIME_WIDTH-1:0] diff_r;
  logic [REM_W-1:0]      rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [REM_W-1:0]      rem_sh, rem_sub;

  // result register
  logic                  out_valid_r;
  tcps_pkg::phase_t      out_phase_r;
  logic                  out_tone_r;
  logic [TIME_WIDTH-1:0] out_time_r;
  logic                  out_prep_r, out_unprep_r, out_mstart_r, out_mstop_r;
  logic                  out_keyer_r, out_fault_r;

  logic [LEN_W-1:0]      cyc_len;
  logic                  tick_in;
  logic                  early_in;

  logic [LEN_W-1:0]      t;
  logic [DUR_W-1:0]      tone_clamp, tone_start;
  logic [LEN_W-1:0]      prep_start;
  logic [LEN_W-1:0]      end_off, delta;
  logic [TIME_WIDTH-1:0] time_nxt;
  logic                  upd_time;
  logic                  prep_p, unprep_p, mstart_p, mstop_p, keyer_p;

  assign cyc_len  = {1'b0, tx_r} + {1'b0, pause_r};
  assign early_in = in_current_time < start_r;
  assign tick_in  = (in_action == tcps_pkg::ACT_TICK) && in_before_finish && !cont_r &&
                    !halted_r;

  assign stat.need_div = tick_in && !early_in && (cyc_len != '0);
  assign stat.div_last = (cnt_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      tx_r        <= DUR_W'(60);
      pause_r     <= DUR_W'(240);
      tone_len_r  <= DUR_W'(5);
      prep_time_r <= DUR_W'(5);
      cont_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (tcps_pkg::cfg_reg_t'(cfg_index))
        tcps_pkg::REG_START_TIME:  start_r     <= cfg_data;
        tcps_pkg::REG_TX_TIME:     tx_r        <= cfg_data[DUR_W-1:0];
        tcps_pkg::REG_PAUSE_TIME:  pause_r     <= cfg_data[DUR_W-1:0];
        tcps_pkg::REG_TONE_LENGTH: tone_len_r  <= cfg_data[DUR_W-1:0];
        tcps_pkg::REG_PREP_TIME:   prep_time_r <= cfg_data[DUR_W-1:0];
        tcps_pkg::REG_CONT_MODE:   cont_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Restoring division of (time - start) by the cycle length; keep the remainder only
  assign rem_sh  = {rem_r[REM_W-2:0], diff_r[TIME_WIDTH-1]};
  assign rem_sub = (rem_sh >= {1'b0, cyc_len}) ? rem_sh - {1'b0, cyc_len} : rem_sh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_action;
      now_r   <= in_current_time;
      bf_r    <= in_before_finish;
      fox_r   <= in_fox_prepared;
      early_r <= early_in;
      diff_r  <= in_current_time - start_r;
      rem_r   <= '0;
      cnt_r   <= CNT_W'(TIME_WIDTH - 1);
    end else if (cmd.step) begin
      diff_r  <= {diff_r[TIME_WIDTH-2:0], 1'b0};
      rem_r   <= rem_sub;
      cnt_r   <= cnt_r - 1'b1;
    end
  end

  // Cycle position; zero when no division ran
  assign t          = rem_r[LEN_W-1:0];
  assign tone_clamp = (tone_len_r < tx_r) ? tone_len_r : tx_r;
  assign tone_start = tx_r - tone_clamp;
  assign prep_start = ({1'b0, prep_time_r} < cyc_len) ? cyc_len - {1'b0, prep_time_r} : '0;

  always_comb begin
    phase_nxt  = phase_r;
    tone_nxt   = tone_r;
    halted_nxt = halted_r;
    upd_time   = 1'b0;
    prep_p     = 1'b0;
    unprep_p   = 1'b0;
    mstart_p   = 1'b0;
    mstop_p    = 1'b0;
    keyer_p    = 1'b0;
    if (!halted_r) begin
      case (act_r)
        tcps_pkg::ACT_START: begin
          prep_p    = !fox_r;
          phase_nxt = tcps_pkg::PH_TX;
          tone_nxt  = 1'b0;
          keyer_p   = 1'b1;
          mstart_p  = 1'b1;
          upd_time  = 1'b1;
        end
        tcps_pkg::ACT_STOP: begin
          phase_nxt = tcps_pkg::PH_PAUSE;
          tone_nxt  = 1'b0;
          keyer_p   = 1'b1;
          mstop_p   = 1'b1;
          unprep_p  = fox_r;
          upd_time  = 1'b1;
        end
        tcps_pkg::ACT_TICK: begin
          if (bf_r && !cont_r) begin
            if (early_r) begin
              halted_nxt = 1'b1;
            end else begin
              upd_time = 1'b1;
              if (t < {1'b0, tone_start}) begin
                if (phase_r != tcps_pkg::PH_TX) begin
                  prep_p    = !fox_r;
                  phase_nxt = tcps_pkg::PH_TX;
                  tone_nxt  = 1'b0;
                  keyer_p   = 1'b1;
                  mstart_p  = 1'b1;
                end
              end else if (t < {1'b0, tx_r}) begin
                if (phase_r != tcps_pkg::PH_TONE) begin
                  phase_nxt = tcps_pkg::PH_TONE;
                  tone_nxt  = 1'b1;
                  keyer_p   = 1'b1;
                end
              end else if (t >= prep_start) begin
                if (phase_r != tcps_pkg::PH_READY) begin
                  prep_p    = !fox_r;
                  phase_nxt = tcps_pkg::PH_READY;
                end
              end else begin
                if (phase_r != tcps_pkg::PH_PAUSE) begin
                  phase_nxt = tcps_pkg::PH_PAUSE;
                  tone_nxt  = 1'b0;
                  keyer_p   = 1'b1;
                  mstop_p   = 1'b1;
                  unprep_p  = fox_r;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Next change: end of transmit or end of cycle, from the new phase
  assign end_off  = (phase_nxt == tcps_pkg::PH_TX || phase_nxt == tcps_pkg::PH_TONE) ?
                    {1'b0, tx_r} : cyc_len;
  assign delta    = end_off - t;
  assign time_nxt = now_r + TIME_WIDTH'(delta);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= tcps_pkg::PH_PAUSE;
      tone_r   <= 1'b0;
      halted_r <= 1'b0;
      change_r <= '0;
    end else if (cmd.finish) begin
      phase_r  <= phase_nxt;
      tone_r   <= tone_nxt;
      halted_r <= halted_nxt;
      if (upd_time) begin
        change_r <= time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_phase_r  <= phase_nxt;
      out_tone_r   <= tone_nxt;
      out_time_r   <= upd_time ? time_nxt : change_r;
      out_prep_r   <= prep_p;
      out_unprep_r <= unprep_p;
      out_mstart_r <= mstart_p;
      out_mstop_r  <= mstop_p;
      out_keyer_r  <= keyer_p;
      out_fault_r  <= halted_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_phase            = out_phase_r;
  assign out_ending_tone_on   = out_tone_r;
  assign out_next_change_time = out_time_r;
  assign out_do_prepare       = out_prep_r;
  assign out_do_unprepare     = out_unprep_r;
  assign out_morse_start      = out_mstart_r;
  assign out_morse_stop       = out_mstop_r;
  assign out_keyer_notify     = out_keyer_r;
  assign out_fault            = out_fault_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |->
      !(out_prep_r || out_unprep_r || out_mstart_r || out_mstop_r || out_keyer_r))
    else $error("command pulse issued while halted");

  a_mstart_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mstart_r) |-> (out_phase_r == tcps_pkg::PH_TX))
    else $error("Morse start outside transmit phase");

  a_mstop_pause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mstop_r) |-> (out_phase_r == tcps_pkg::PH_PAUSE))
    else $error("Morse stop outside pause phase");

endmodule

`default_nettype wire
